@@ src/bitplane_popcount_dot_product_top_macros.svh @@
// Assertion macros for the bit-plane popcount dot product block.
// Used by the top level; no other dependencies.
`ifndef BITPLANE_POPCOUNT_DOT_PRODUCT_TOP_MACROS_SVH
`define BITPLANE_POPCOUNT_DOT_PRODUCT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpd check failed");

// Next-cycle implication, checked outside reset.
`define BPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpd check failed");

`endif

@@ src/bpd_pkg.sv @@
// Shared types, constants and the popcount function for the bit-plane
// popcount dot product block. No dependencies.
`default_nettype none

package bpd_pkg;

  localparam int PORT_BITS       = 64;
  localparam int NUM_PLANE_PORTS = 8;
  localparam int POP_W           = 7;
  localparam int SUM_W           = 40;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd1;

  localparam logic [1:0] MODE_AND = 2'd0;
  localparam logic [1:0] MODE_XOR = 2'd1;
  localparam logic [1:0] MODE_POP = 2'd2;

  typedef logic [1:0] lane_op_t;
  localparam lane_op_t LOP_OFF  = 2'd0;
  localparam lane_op_t LOP_AND  = 2'd1;
  localparam lane_op_t LOP_XOR  = 2'd2;
  localparam lane_op_t LOP_DATA = 2'd3;

  typedef struct packed {
    logic load_sum;
    logic accumulate;
    logic emit;
  } merge_ctrl_t;

  localparam logic [2:0] NIBBLE_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [POP_W-1:0] popcount_word(input logic [PORT_BITS-1:0] w);
    logic [2:0] l0 [16];
    logic [3:0] l1 [8];
    logic [4:0] l2 [4];
    logic [5:0] l3 [2];
    for (int k = 0; k < 16; k++) begin
      l0[k] = NIBBLE_ONES[w[4*k +: 4] & NIBBLE_MASK];
    end
    for (int k = 0; k < 8; k++) begin
      l1[k] = {1'b0, l0[2*k]} + {1'b0, l0[2*k+1]};
    end
    for (int k = 0; k < 4; k++) begin
      l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
    end
    for (int k = 0; k < 2; k++) begin
      l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
    end
    return {1'b0, l3[0]} + {1'b0, l3[1]};
  endfunction

endpackage

`default_nettype wire

@@ src/bpd_lane.sv @@
// One plane lane: masks the data word, combined with a plane word in the AND and
// XOR ops, and registers its popcount. Depends on bpd_pkg.
`default_nettype none

module bpd_lane #(
  parameter int CNT_W = 7
) (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire bpd_pkg::lane_op_t             op,
  input  wire logic [bpd_pkg::PORT_BITS-1:0] data,
  input  wire logic [bpd_pkg::PORT_BITS-1:0] plane,
  input  wire logic [bpd_pkg::PORT_BITS-1:0] mask,
  output logic      [CNT_W-1:0]              cnt
);
  import bpd_pkg::*;

  logic [PORT_BITS-1:0] word;
  logic [POP_W-1:0]     pop;
  logic [CNT_W-1:0]     cnt_next;

  always_comb begin
    case (op)
      LOP_AND:  word = plane & data & mask;
      LOP_XOR:  word = (plane ^ data) & mask;
      LOP_DATA: word = data & mask;
      default:  word = '0;
    endcase
  end

  assign pop      = popcount_word(word);
  assign cnt_next = CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ src/bpd_merge.sv @@
// Merge stage: weights and adds the lane counts, then runs the saturating
// 40-bit accumulator and holds the result beat. Depends on bpd_pkg.
`default_nettype none

module bpd_merge #(
  parameter int MAX_PLANES = 8,
  parameter int CNT_W      = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bpd_pkg::merge_ctrl_t                ctrl,
  input  wire logic [MAX_PLANES-1:0][CNT_W-1:0]    cnt,
  output logic      [bpd_pkg::SUM_W-1:0]           dot_sum,
  output logic                                     saturated
);
  import bpd_pkg::*;

  localparam int WSUM_W = CNT_W + MAX_PLANES;

  logic [WSUM_W-1:0] wsum_next;
  logic [WSUM_W-1:0] wsum;
  logic [SUM_W-1:0]  running_sum;
  logic              saturate_flag;
  logic [SUM_W:0]    total;
  logic              over;
  logic [SUM_W-1:0]  sum_next;
  logic              flag_next;

  always_comb begin
    wsum_next = '0;
    for (int j = 0; j < MAX_PLANES; j++) begin
      wsum_next = wsum_next + (WSUM_W'(cnt[j]) << j);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      wsum <= wsum_next;
    end
  end

  assign total     = {1'b0, running_sum} + (SUM_W + 1)'(wsum);
  assign over      = total >= {1'b0, SUM_MAX};
  assign sum_next  = over ? SUM_MAX : total[SUM_W-1:0];
  assign flag_next = saturate_flag | over;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      saturate_flag <= 1'b0;
    end else if (ctrl.accumulate) begin
      if (ctrl.emit) begin
        running_sum   <= '0;
        saturate_flag <= 1'b0;
      end else begin
        running_sum   <= sum_next;
        saturate_flag <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      dot_sum   <= sum_next;
      saturated <= flag_next;
    end
  end

endmodule

`default_nettype wire

@@ src/bitplane_popcount_dot_product_top.sv @@
// Bit-plane weighted popcount dot product: top level with the input stage,
// plane lanes, merge stage and result handshake.
// Depends on bpd_pkg, bpd_lane, bpd_merge and the assertion macro header.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one 64-bit data word, the
//   matching word of each query plane, valid_bytes and last_word per beat.
//   The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   combine_mode (index 0) and plane_count (index 1); it is always ready; the
//   user must write it only while the block is idle (not enforced by the block).
//   The output channel (out_valid/out_ready) carries dot_sum and saturated,
//   one beat per vector, after the beat marked last_word.
// Timing:
//   An accepted beat passes through the lane registers, the weighted sum
//   register and the accumulator and output register; out_valid rises when
//   the last beat reaches the output register. Throughput is one input beat
//   per cycle unless a last beat stalls on out_ready; the lanes and the adder
//   tree work side by side and the 40-bit saturating add sets the rate.
// Reset:
//   rst clears the pipeline, the accumulator and the flag, and loads
//   combine_mode = AND and plane_count = 4.
// Stall:
//   While a result waits on out_ready, non-last beats keep flowing into the
//   accumulator; only the next last beat holds at the merge stage, and the
//   pipeline backs up behind it.
`default_nettype none

`include "bitplane_popcount_dot_product_top_macros.svh"

module bitplane_popcount_dot_product_top #(
  parameter int MAX_PLANES = 8,
  parameter int WORD_BITS  = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  data_word,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_0,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_1,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_2,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_3,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_4,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_5,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_6,
  input  wire logic [bpd_pkg::PORT_BITS-1:0]  plane_word_7,
  input  wire logic [3:0]                     valid_bytes,
  input  wire logic                           last_word,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bpd_pkg::SUM_W-1:0]      dot_sum,
  output logic                                saturated
);
  import bpd_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [1:0] combine_mode;
  logic [3:0] plane_count;
  logic [3:0] plane_limit;

  logic [NUM_PLANE_PORTS-1:0][PORT_BITS-1:0] plane_words;
  logic [PORT_BITS-1:0]                      mask;
  logic [MAX_PLANES-1:0][1:0]                lane_ops;
  logic [MAX_PLANES-1:0][CNT_W-1:0]          lane_cnt;

  logic        stage1_valid;
  logic        stage1_last;
  logic        stage2_valid;
  logic        stage2_last;
  logic        acc_go;
  logic        adv2;
  logic        adv1;
  merge_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_AND;
      plane_count  <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COMBINE_MODE: combine_mode <= cfg_data[1:0];
        REG_PLANE_COUNT:  plane_count  <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign plane_limit = (plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : plane_count;

  assign plane_words[0] = plane_word_0;
  assign plane_words[1] = plane_word_1;
  assign plane_words[2] = plane_word_2;
  assign plane_words[3] = plane_word_3;
  assign plane_words[4] = plane_word_4;
  assign plane_words[5] = plane_word_5;
  assign plane_words[6] = plane_word_6;
  assign plane_words[7] = plane_word_7;

  always_comb begin
    for (int i = 0; i < PORT_BITS; i++) begin
      mask[i] = (4'(i / 8) < valid_bytes) && (i < WORD_BITS);
    end
  end

  // Pipeline flow: the merge stage holds only a last beat on a full output.
  assign acc_go   = stage2_valid && (!stage2_last || !out_valid || out_ready);
  assign adv2     = !stage2_valid || acc_go;
  assign adv1     = !stage1_valid || adv2;
  assign in_ready = adv1;

  assign ctrl.load_sum   = adv2 && stage1_valid;
  assign ctrl.accumulate = acc_go;
  assign ctrl.emit       = acc_go && stage2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (adv1) begin
        stage1_valid <= in_valid;
      end
      if (adv2) begin
        stage2_valid <= stage1_valid;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      stage1_last <= last_word;
    end
    if (adv2) begin
      stage2_last <= stage1_last;
    end
  end

  for (genvar j = 0; j < MAX_PLANES; j++) begin : g_lane
    always_comb begin
      case (combine_mode)
        MODE_AND: lane_ops[j] = (4'(j) < plane_limit) ? LOP_AND : LOP_OFF;
        MODE_XOR: lane_ops[j] = (4'(j) < plane_limit) ? LOP_XOR : LOP_OFF;
        MODE_POP: lane_ops[j] = (j == 0) ? LOP_DATA : LOP_OFF;
        default:  lane_ops[j] = LOP_OFF;
      endcase
    end

    bpd_lane #(
      .CNT_W (CNT_W)
    ) u_lane (
      .clk   (clk),
      .load  (adv1),
      .op    (lane_ops[j]),
      .data  (data_word),
      .plane (plane_words[j]),
      .mask  (mask),
      .cnt   (lane_cnt[j])
    );
  end

  bpd_merge #(
    .MAX_PLANES (MAX_PLANES),
    .CNT_W      (CNT_W)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cnt       (lane_cnt),
    .dot_sum   (dot_sum),
    .saturated (saturated)
  );

  `BPD_ASSERT_IMP(a_emit_slot_free, clk, rst, ctrl.emit, (!out_valid || out_ready))
  `BPD_ASSERT_NXT(a_emit_shows, clk, rst, ctrl.emit, out_valid)
  `BPD_ASSERT_IMP(a_sat_at_max, clk, rst, (out_valid && saturated), (dot_sum == SUM_MAX))

endmodule

`default_nettype wire
